[src/bks_pkg.sv]
// ----------------------------------------------------------------------------
// bks_pkg
// Shared types and constants for the bounded key set: request kinds, the
// configuration register layout and the controller/datapath interface.
// ----------------------------------------------------------------------------
package bks_pkg;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // latch the request, restart the scan pointer
        logic clear_set;  // empty the set
        logic idx_inc;    // advance the scan/shift pointer
        logic set_found;  // key matched the current entry
        logic append;     // write key at the end and grow the count
        logic shift_wr;   // move the current entry down one place
        logic dec;        // shrink the count after a remove
        logic emit;       // load the result register
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        mode_t mode;      // kind of the request in progress
        logic  hit;       // current entry equals the key
        logic  last;      // pointer is on the last used entry, or set empty
        logic  room;      // count is below the effective capacity
        logic  out_free;  // result register can take a new result
    } dp_status_t;

endpackage

[src/bks_ctrl.sv]
// ----------------------------------------------------------------------------
// bks_ctrl
// Controller state machine: sequences the scan, the compacting shift and the
// hand-over of the result for one request at a time.
// ----------------------------------------------------------------------------
module bks_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           in_mode,
    output logic                 in_ready,
    input  bks_pkg::dp_status_t  status,
    output bks_pkg::dp_cmd_t     cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_SHIFT = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (in_mode == bks_pkg::MODE_CLEAR)
                    begin
                        cmd.clear_set = 1'b1;
                        state_next    = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (status.hit)
                begin
                    cmd.set_found = 1'b1;
                    if (status.mode == bks_pkg::MODE_REMOVE)
                    begin
                        // Removing the tail entry needs no shift at all.
                        if (status.last)
                        begin
                            cmd.dec    = 1'b1;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            cmd.idx_inc = 1'b1;
                            state_next  = ST_SHIFT;
                        end
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
                else if (status.last)
                begin
                    if ((status.mode == bks_pkg::MODE_ADD) && status.room)
                    begin
                        cmd.append = 1'b1;
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_SHIFT:
            begin
                cmd.shift_wr = 1'b1;
                if (status.last)
                begin
                    cmd.dec    = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[src/bks_dp.sv]
// ----------------------------------------------------------------------------
// bks_dp
// Datapath: entry memory with a registered read port, scan pointer, count,
// capacity register, request latch and the result register.
// ----------------------------------------------------------------------------
module bks_dp #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32,
    parameter int CNT_W     = 5,
    parameter int IDX_W     = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [bks_pkg::CAP_W-1:0]   cfg_wdata,
    input  logic [1:0]                  in_mode,
    input  logic [KEY_WIDTH-1:0]        in_key,
    input  bks_pkg::dp_cmd_t            cmd,
    output bks_pkg::dp_status_t         status,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        ok,
    output logic                        found,
    output logic [CNT_W-1:0]            count
);

    localparam int CMP_W = (CNT_W > bks_pkg::CAP_W) ? CNT_W : bks_pkg::CAP_W;

    logic [KEY_WIDTH-1:0]        mem [0:DEPTH-1];
    logic [KEY_WIDTH-1:0]        rd_data_reg;

    logic [bks_pkg::CAP_W-1:0]   cap_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic [IDX_W-1:0]            idx_next;
    logic [IDX_W-1:0]            idx_prev;
    bks_pkg::mode_t              mode_reg;
    logic [KEY_WIDTH-1:0]        key_reg;
    logic                        ok_reg;
    logic                        found_reg;

    logic                        out_valid_reg;
    logic                        out_ok_reg;
    logic                        out_found_reg;
    logic [CNT_W-1:0]            out_count_reg;

    logic [CMP_W-1:0]            count_ext;
    logic [CMP_W-1:0]            cap_ext;
    logic [CNT_W-1:0]            count_minus1;

    // The read address follows the next pointer value, so rd_data_reg always
    // holds the entry that idx_reg points at.
    always_comb
    begin
        if (cmd.load)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + 1'b1;
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    assign idx_prev = idx_reg - 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            mem[count_reg[IDX_W-1:0]] <= key_reg;
        end
        else if (cmd.shift_wr)
        begin
            mem[idx_prev] <= rd_data_reg;
        end
        rd_data_reg <= mem[idx_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= bks_pkg::CAP_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (cmd.clear_set)
            begin
                count_reg <= '0;
            end
            else if (cmd.append)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (cmd.dec)
            begin
                count_reg <= count_minus1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.load)
        begin
            mode_reg  <= bks_pkg::mode_t'(in_mode);
            key_reg   <= in_key;
            ok_reg    <= cmd.clear_set;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.append || cmd.dec)
            begin
                ok_reg <= 1'b1;
            end
            if (cmd.set_found)
            begin
                found_reg <= 1'b1;
            end
        end
        if (cmd.emit)
        begin
            out_ok_reg    <= ok_reg;
            out_found_reg <= found_reg;
            out_count_reg <= count_reg;
        end
    end

    assign count_minus1 = count_reg - 1'b1;
    assign count_ext    = CMP_W'(count_reg);
    assign cap_ext      = CMP_W'(cap_reg);

    always_comb
    begin
        status.mode     = mode_reg;
        status.hit      = (count_reg != '0) && (rd_data_reg == key_reg);
        status.last     = (count_reg == '0) || (CNT_W'(idx_reg) == count_minus1);
        status.room     = (count_ext < cap_ext) && (count_ext < CMP_W'(DEPTH));
        status.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign ok        = out_ok_reg;
    assign found     = out_found_reg;
    assign count     = out_count_reg;

endmodule

[src/bounded_unordered_key_set.sv]
// ----------------------------------------------------------------------------
// bounded_unordered_key_set
// Set of distinct keys held compactly in a memory, with add, remove, query
// and clear requests and one result per request.
// ----------------------------------------------------------------------------
// One request is handled at a time. A clear goes from acceptance straight to
// the done state. Any other request walks the single read port of the entry
// memory one entry per cycle, first to find the key and then, for a remove,
// to move each later entry down one place, so the scan and the shift together
// visit every used entry once. A query or a refused add that finds its key
// stops the scan there. The result waits in the done state until the output
// register can take it. A new request is taken as soon as the result has been
// placed in the output register, even if it has not yet been collected. The
// capacity register may only be written while the block is idle; values above
// DEPTH behave as DEPTH.
module bounded_unordered_key_set #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32,
    localparam int CNT_W    = $clog2(DEPTH + 1),
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [bks_pkg::CAP_W-1:0]   cfg_wdata,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  mode,
    input  logic [KEY_WIDTH-1:0]        key,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        ok,
    output logic                        found,
    output logic [CNT_W-1:0]            count
);

    bks_pkg::dp_cmd_t     cmd;
    bks_pkg::dp_status_t  status;

    bks_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_mode  (mode),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    bks_dp #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH),
        .CNT_W     (CNT_W),
        .IDX_W     (IDX_W)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_mode   (mode),
        .in_key    (key),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ok        (ok),
        .found     (found),
        .count     (count)
    );

`ifndef SYNTHESIS
    // The set can never report more keys than the memory holds.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (count <= CNT_W'(DEPTH)))
    else $error("result count exceeds store depth");

    // Once a request is taken, in_ready is low in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while previous one still in progress");

    // A key that was present and not removed leaves a non-empty set.
    a_found_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && found && !ok) |-> (count != '0))
    else $error("found key reported with an empty set");
`endif

endmodule
